>>> rtl/strg_pkg.sv
// Package for the stepper trapezoid ramp generator.
// Holds field widths, event and mode codes, register indexes and sequencer states.
// No dependencies.
package strg_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned SPD_W   = 18;
  localparam int unsigned TMR_W   = 48;
  localparam int unsigned ACC_W   = 24;
  localparam int unsigned RATE_W  = 27;
  localparam int unsigned PER_W   = 24;
  localparam int unsigned DIV_NW  = 2 * SPD_W;
  localparam int unsigned DIV_DW  = ACC_W + 1;
  localparam int unsigned IN_W    = 104;
  localparam int unsigned OUT_W   = 104;
  localparam int unsigned ADDR_W  = 5;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_ALARM = 2'd2,
    OP_ZERO  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ACCEL = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_DECEL = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_MAX_SPEED   = 3'd0,
    REG_START_SPEED = 3'd1,
    REG_ACCEL       = 3'd2,
    REG_TIMER_RATE  = 3'd3,
    REG_PERIOD_MIN  = 3'd4,
    REG_PERIOD_MAX  = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REM,
    S_STOP_GO,
    S_STOP_WAIT,
    S_ACC_GO,
    S_ACC_WAIT,
    S_PER_GO,
    S_PER_WAIT,
    S_OUT
  } state_e;

endpackage

>>> rtl/strg_div.sv
// Restoring divider for the ramp generator, one quotient bit per cycle.
// Shared by the period, speed step and stopping distance divisions. No dependencies.
module strg_div #(
  parameter int unsigned NUM_W = 36,
  parameter int unsigned DEN_W = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W:0]   shifted;
  logic             ge;

  // Load the operands on start, else shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    ge      = shifted >= {1'b0, den_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quo_d   = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = ge ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> rtl/stepper_trapezoid_ramp_generator.sv
// Top level of the stepper trapezoid ramp generator: APB registers, event sequencer,
// axis state and result register. Depends on strg_pkg and strg_div.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   tvalid/tready             tuser: operation; tdata: event fields
// m_axis    out  tvalid/tready             tdata: result fields; tlast: end of motion
// apb       in   psel/penable/pwrite       six registers at 4*i, pready always high
//
// Sequencer paths per item: stop, zero, idle and stopping alarms go straight to the
// output; a rising step edge that ends the move passes the remaining-distance check
// first. One pass of the shared divider has a launch, 36 quotient bits and a done flag;
// a start or a falling step edge makes one pass (period), a rising edge up to three
// (stop distance, speed step, period), two in continuous mode. Reset loads the register
// defaults and parks the axis at position zero. A result waits in the output register;
// the sequencer holds in its last state while that register is still full and not taken.
module stepper_trapezoid_ramp_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // tuser: operation[1:0]
  // tdata: direction[0], speed_request[18:1], step_count[49:19], continuous[50],
  //        alarm_time[98:51], zero fill[103:99]
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [strg_pkg::IN_W-1:0]    s_axis_tdata,
  input  logic [1:0]                   s_axis_tuser,
  // tdata: step_level[0], dir_level[1], motion_state[3:2], position_now[35:4],
  //        speed_now[53:36], next_alarm[101:54], timer_armed[102], zero fill[103]
  // tlast: this item ended the motion
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [strg_pkg::OUT_W-1:0]   m_axis_tdata,
  output logic                         m_axis_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [strg_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import strg_pkg::*;

  // Configuration registers
  logic [SPD_W-1:0]  max_spd_q, start_spd_q;
  logic [ACC_W-1:0]  accel_q;
  logic [RATE_W-1:0] rate_q;
  logic [PER_W-1:0]  pmin_q, pmax_q;

  // Axis state
  mode_e            mode_q, mode_d;
  logic             head_q, head_d;
  logic             pulse_q, pulse_d;
  logic             stop_q, stop_d;
  logic             cont_q, cont_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] tgt_q, tgt_d;
  logic [SPD_W-1:0] cs_q, cs_d;
  logic [SPD_W-1:0] gs_q, gs_d;

  // Per-item working registers
  state_e            state_q, state_d;
  logic              is_start_q, is_start_d;
  logic [TMR_W-1:0]  alarm_q, alarm_d;
  logic [POS_W-1:0]  rem_q, rem_d;
  logic [DIV_NW-1:0] sq_q, sq_d;
  logic [TMR_W-1:0]  next_q, next_d;
  logic              armed_q, armed_d;
  logic              done_q, done_d;

  // Result register
  logic              ov_q, ov_d;
  logic [OUT_W-1:0]  odata_q, odata_d;

  // Divider
  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;

  // Item fields
  op_e              in_op;
  logic             in_dir, in_cont;
  logic [SPD_W-1:0] in_spd;
  logic [30:0]      in_steps;
  logic [TMR_W-1:0] in_alarm;

  logic              in_acc, cfg_wr;
  logic [POS_W-1:0]  rem_calc;
  logic [SPD_W-1:0]  dv;
  logic [ACC_W:0]    dstep;
  logic [SPD_W+ACC_W:0] sum;
  logic [DIV_NW:0]   stop_dist;
  logic [DIV_NW-1:0] pclamp_a;
  logic [PER_W-1:0]  pclamp, per_p, half;
  logic              finish;

  assign in_op    = op_e'(s_axis_tuser);
  assign in_dir   = s_axis_tdata[0];
  assign in_spd   = s_axis_tdata[18:1];
  assign in_steps = s_axis_tdata[49:19];
  assign in_cont  = s_axis_tdata[50];
  assign in_alarm = s_axis_tdata[98:51];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite;

  // Register read back
  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_MAX_SPEED:   prdata = 32'(max_spd_q);
      REG_START_SPEED: prdata = 32'(start_spd_q);
      REG_ACCEL:       prdata = 32'(accel_q);
      REG_TIMER_RATE:  prdata = 32'(rate_q);
      REG_PERIOD_MIN:  prdata = 32'(pmin_q);
      REG_PERIOD_MAX:  prdata = 32'(pmax_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_spd_q   <= SPD_W'(20000);
      start_spd_q <= SPD_W'(500);
      accel_q     <= ACC_W'(20000);
      rate_q      <= RATE_W'(1000000);
      pmin_q      <= PER_W'(10);
      pmax_q      <= PER_W'(100000);
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MAX_SPEED:   max_spd_q   <= pwdata[SPD_W-1:0];
        REG_START_SPEED: start_spd_q <= pwdata[SPD_W-1:0];
        REG_ACCEL:       accel_q     <= pwdata[ACC_W-1:0];
        REG_TIMER_RATE:  rate_q      <= pwdata[RATE_W-1:0];
        REG_PERIOD_MIN:  pmin_q      <= pwdata[PER_W-1:0];
        REG_PERIOD_MAX:  pmax_q      <= pwdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DIV_DW'(1);
    unique case (state_q)
      S_STOP_GO: begin
        div_start = 1'b1;
        div_num   = sq_q;
        div_den   = (accel_q == '0) ? DIV_DW'(1) : {accel_q, 1'b0};
      end
      S_ACC_GO: begin
        div_start = 1'b1;
        div_num   = DIV_NW'(accel_q);
        div_den   = (cs_q == '0) ? DIV_DW'(1) : DIV_DW'(cs_q);
      end
      S_PER_GO: begin
        div_start = (cs_q != '0);
        div_num   = DIV_NW'(rate_q);
        div_den   = DIV_DW'(cs_q);
      end
      default: ;
    endcase
  end

  strg_div #(
    .NUM_W(DIV_NW),
    .DEN_W(DIV_DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Shared datapath terms
  always_comb begin
    rem_calc  = head_q ? (tgt_q - pos_q) : (pos_q - tgt_q);
    dv        = cs_q - start_spd_q;
    dstep     = div_quo[ACC_W:0] + (ACC_W+1)'(1);
    sum       = (SPD_W+ACC_W+1)'(cs_q) + (SPD_W+ACC_W+1)'(dstep);
    stop_dist = {1'b0, div_quo} + (DIV_NW+1)'(1);
    pclamp_a  = (div_quo < DIV_NW'(pmin_q)) ? DIV_NW'(pmin_q) : div_quo;
    pclamp    = (pclamp_a > DIV_NW'(pmax_q)) ? pmax_q : pclamp_a[PER_W-1:0];
    per_p     = (state_q == S_PER_GO) ? pmax_q : pclamp;
    half      = per_p >> 1;
    if (!is_start_q && half < pmin_q) begin
      half = pmin_q;
    end
    finish = ((state_q == S_PER_GO) && (cs_q == '0)) || ((state_q == S_PER_WAIT) && div_done);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_START: state_d = S_PER_GO;
            OP_ALARM: begin
              if (mode_q == MODE_IDLE || stop_q) begin
                state_d = S_OUT;
              end else if (pulse_q) begin
                state_d = S_PER_GO;
              end else begin
                state_d = cont_q ? S_ACC_GO : S_REM;
              end
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_REM: begin
        if (rem_calc == '0 || rem_calc[POS_W-1]) begin
          state_d = S_OUT;
        end else if (cs_q <= start_spd_q) begin
          state_d = S_ACC_GO;
        end else begin
          state_d = S_STOP_GO;
        end
      end
      S_STOP_GO:   state_d = S_STOP_WAIT;
      S_STOP_WAIT: if (div_done) state_d = S_ACC_GO;
      S_ACC_GO:    state_d = S_ACC_WAIT;
      S_ACC_WAIT:  if (div_done) state_d = S_PER_GO;
      S_PER_GO:    state_d = (cs_q == '0) ? S_OUT : S_PER_WAIT;
      S_PER_WAIT:  if (div_done) state_d = S_OUT;
      S_OUT:       if (!ov_q || m_axis_tready) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Axis and result updates
  always_comb begin
    mode_d     = mode_q;
    head_d     = head_q;
    pulse_d    = pulse_q;
    stop_d     = stop_q;
    cont_d     = cont_q;
    pos_d      = pos_q;
    tgt_d      = tgt_q;
    cs_d       = cs_q;
    gs_d       = gs_q;
    is_start_d = is_start_q;
    alarm_d    = alarm_q;
    rem_d      = rem_q;
    sq_d       = sq_q;
    next_d     = next_q;
    armed_d    = armed_q;
    done_d     = done_q;
    ov_d       = ov_q && !m_axis_tready;
    odata_d    = odata_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          is_start_d = 1'b0;
          alarm_d    = in_alarm;
          next_d     = '0;
          armed_d    = 1'b0;
          done_d     = 1'b0;
          unique case (in_op)
            OP_START: begin
              is_start_d = 1'b1;
              head_d     = in_dir;
              gs_d       = (in_spd > max_spd_q) ? max_spd_q : in_spd;
              cs_d       = start_spd_q;
              cont_d     = in_cont;
              stop_d     = 1'b0;
              pulse_d    = 1'b0;
              mode_d     = MODE_ACCEL;
              if (!in_cont) begin
                tgt_d = in_dir ? (pos_q + POS_W'(in_steps)) : (pos_q - POS_W'(in_steps));
              end
            end
            OP_STOP: begin
              if (mode_q != MODE_IDLE) begin
                stop_d  = 1'b1;
                armed_d = 1'b1;
              end
            end
            OP_ZERO: begin
              pos_d  = '0;
              stop_d = 1'b0;
              mode_d = MODE_IDLE;
              cs_d   = '0;
            end
            default: begin
              if (mode_q != MODE_IDLE) begin
                if (stop_q) begin
                  pulse_d = 1'b0;
                  mode_d  = MODE_IDLE;
                  cs_d    = '0;
                  stop_d  = 1'b0;
                  done_d  = 1'b1;
                end else begin
                  pulse_d = !pulse_q;
                  if (!pulse_q) begin
                    pos_d = head_q ? (pos_q + POS_W'(1)) : (pos_q - POS_W'(1));
                  end
                end
              end
            end
          endcase
        end
      end
      S_REM: begin
        rem_d = rem_calc;
        sq_d  = DIV_NW'(dv) * DIV_NW'(dv);
        if (rem_calc == '0 || rem_calc[POS_W-1]) begin
          pulse_d = 1'b0;
          mode_d  = MODE_IDLE;
          cs_d    = '0;
          stop_d  = 1'b0;
          done_d  = 1'b1;
        end
      end
      S_STOP_WAIT: begin
        if (div_done && ((DIV_NW+1)'(rem_q) <= stop_dist)) begin
          mode_d = MODE_DECEL;
          gs_d   = start_spd_q;
        end
      end
      S_ACC_WAIT: begin
        if (div_done) begin
          if (cs_q < gs_q) begin
            mode_d = MODE_ACCEL;
            cs_d   = (sum > (SPD_W+ACC_W+1)'(gs_q)) ? gs_q : sum[SPD_W-1:0];
          end else if (cs_q > gs_q) begin
            mode_d = MODE_DECEL;
            if (cs_q <= start_spd_q || dstep >= (ACC_W+1)'(dv)) begin
              cs_d = start_spd_q;
            end else begin
              cs_d = cs_q - dstep[SPD_W-1:0];
            end
          end else begin
            mode_d = MODE_RUN;
          end
        end
      end
      S_OUT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          odata_d = {done_q, armed_q, next_q, cs_q, pos_q, mode_q, head_q, pulse_q};
        end
      end
      default: ;
    endcase
    // Period pass finished, or skipped at zero speed: form the next alarm time
    if (finish) begin
      armed_d = 1'b1;
      next_d  = is_start_q ? TMR_W'(half) : (alarm_q + TMR_W'(half));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_IDLE;
      head_q  <= 1'b1;
      pulse_q <= 1'b0;
      stop_q  <= 1'b0;
      cont_q  <= 1'b0;
      pos_q   <= '0;
      tgt_q   <= '0;
      cs_q    <= '0;
      gs_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      head_q  <= head_d;
      pulse_q <= pulse_d;
      stop_q  <= stop_d;
      cont_q  <= cont_d;
      pos_q   <= pos_d;
      tgt_q   <= tgt_d;
      cs_q    <= cs_d;
      gs_q    <= gs_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_start_q <= is_start_d;
    alarm_q    <= alarm_d;
    rem_q      <= rem_d;
    sq_q       <= sq_d;
    next_q     <= next_d;
    armed_q    <= armed_d;
    done_q     <= done_d;
    odata_q    <= odata_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {1'b0, odata_q[OUT_W-2:0]};
  assign m_axis_tlast  = odata_q[OUT_W-1];

endmodule

>>> tb/sv/tb_top.sv
// Testbench for the stepper trapezoid ramp generator: random and directed events,
// APB register phases and a scoreboard that predicts every result item.
// Depends on strg_pkg and the stepper_trapezoid_ramp_generator RTL.
`timescale 1ns / 1ps

import strg_pkg::*;

class ramp_scoreboard;
  // predictor copy of registers and axis state
  logic [17:0] max_spd, start_spd;
  logic [23:0] accel;
  logic [26:0] rate;
  logic [23:0] pmin, pmax;
  mode_e       mode;
  logic        heading, pulse, stop_pend, cont;
  logic [31:0] pos, target;
  logic [17:0] spd, goal;
  logic [103:0] pending_q[$];
  int          fails;

  function void reset_state();
    max_spd = 20000; start_spd = 500; accel = 20000; rate = 1000000;
    pmin = 10; pmax = 100000;
    mode = MODE_IDLE; heading = 1; pulse = 0; stop_pend = 0; cont = 0;
    pos = 0; target = 0; spd = 0; goal = 0;
    pending_q.delete();
    fails = 0;
  endfunction

  function void write_reg(reg_e idx, logic [31:0] v);
    case (idx)
      REG_MAX_SPEED:   max_spd = v[17:0];
      REG_START_SPEED: start_spd = v[17:0];
      REG_ACCEL:       accel = v[23:0];
      REG_TIMER_RATE:  rate = v[26:0];
      REG_PERIOD_MIN:  pmin = v[23:0];
      REG_PERIOD_MAX:  pmax = v[23:0];
      default: ;
    endcase
  endfunction

  function longint unsigned period_for(longint unsigned sps);
    longint unsigned p;
    if (sps == 0) return pmax;
    p = rate / sps;
    if (p < pmin) p = pmin;
    if (p > pmax) p = pmax;
    return p;
  endfunction

  function longint unsigned stop_distance(longint unsigned s);
    longint unsigned dv, dd;
    if (s <= start_spd) return 0;
    dv = s - start_spd;
    dd = 2 * longint'(accel);
    if (dd == 0) dd = 1;
    return dv * dv / dd + 1;
  endfunction

  // advance the predictor by one event and queue its result
  function void note_event(op_e op, logic [103:0] d);
    logic [47:0] nxt;
    logic armed, done, ended;
    logic [31:0] diff;
    longint unsigned req, half, dstep, cur;
    nxt = 0; armed = 0; done = 0; ended = 0;
    case (op)
      OP_START: begin
        heading = d[0];
        req = d[18:1];
        goal = (req > max_spd) ? max_spd : req[17:0];
        spd = start_spd;
        cont = d[50];
        stop_pend = 0; pulse = 0; mode = MODE_ACCEL;
        if (!cont) target = heading ? pos + d[49:19] : pos - d[49:19];
        nxt = period_for(start_spd) / 2;
        armed = 1;
      end
      OP_STOP: if (mode != MODE_IDLE) begin
        stop_pend = 1; armed = 1;
      end
      OP_ZERO: begin
        pos = 0; stop_pend = 0; mode = MODE_IDLE; spd = 0;
      end
      default: if (mode != MODE_IDLE) begin
        if (stop_pend) begin
          pulse = 0; mode = MODE_IDLE; spd = 0; stop_pend = 0; ended = 1;
        end else begin
          pulse = ~pulse;
          if (pulse) begin
            pos = heading ? pos + 1 : pos - 1;
            if (!cont) begin
              diff = heading ? target - pos : pos - target;
              if ($signed(diff) <= 0) begin
                pulse = 0; mode = MODE_IDLE; spd = 0; stop_pend = 0; ended = 1;
              end else if (longint'(diff) <= stop_distance(spd)) begin
                mode = MODE_DECEL; goal = start_spd;
              end
            end
            if (!ended) begin
              dstep = accel / ((spd != 0) ? longint'(spd) : 1) + 1;
              cur = spd;
              if (spd < goal) begin
                mode = MODE_ACCEL;
                cur = cur + dstep;
                if (cur > goal) cur = goal;
              end else if (spd > goal) begin
                mode = MODE_DECEL;
                if (spd <= start_spd || dstep >= cur - start_spd) cur = start_spd;
                else cur = cur - dstep;
              end else mode = MODE_RUN;
              spd = cur[17:0];
            end
          end
        end
        if (ended) done = 1;
        else begin
          half = period_for(spd) / 2;
          if (half < pmin) half = pmin;
          nxt = d[98:51] + half[47:0];
          armed = 1;
        end
      end
    endcase
    pending_q.push_back({done, armed, nxt, spd, pos, mode, heading, pulse});
  endfunction

  function void check_result(logic [103:0] got);
    logic [103:0] exp_r;
    if (pending_q.size() == 0) begin
      $error("result with no expectation: %h", got);
      fails++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (got[0] !== exp_r[0]) begin
      $error("step_level exp %0d got %0d", exp_r[0], got[0]); fails++; end
    if (got[1] !== exp_r[1]) begin
      $error("dir_level exp %0d got %0d", exp_r[1], got[1]); fails++; end
    if (got[3:2] !== exp_r[3:2]) begin
      $error("motion_state exp %0d got %0d", exp_r[3:2], got[3:2]); fails++; end
    if (got[35:4] !== exp_r[35:4]) begin
      $error("position_now exp %0d got %0d", $signed(exp_r[35:4]), $signed(got[35:4]));
      fails++;
    end
    if (got[53:36] !== exp_r[53:36]) begin
      $error("speed_now exp %0d got %0d", exp_r[53:36], got[53:36]); fails++; end
    if (got[101:54] !== exp_r[101:54]) begin
      $error("next_alarm exp %0d got %0d", exp_r[101:54], got[101:54]); fails++; end
    if (got[102] !== exp_r[102]) begin
      $error("timer_armed exp %0d got %0d", exp_r[102], got[102]); fails++; end
    if (got[103] !== exp_r[103]) begin
      $error("motion_end exp %0d got %0d", exp_r[103], got[103]); fails++; end
  endfunction
endclass

module tb_top;
  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  ramp_scoreboard sb;
  int          n_sent;
  bit          no_idle;

  stepper_trapezoid_ramp_generator i_dut (.*);

  always #4 clk_i = ~clk_i;

  // receiver: random stalls, none during the quiet stretch
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result({m_axis_tlast, m_axis_tdata[102:0]});
    m_axis_tready <= no_idle || ($urandom_range(99) >= 9);
  end

  task automatic apb_write(reg_e idx, logic [31:0] v);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 5'(idx) << 2; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(idx, v);
    @(posedge clk_i);
  endtask

  // hand one event to the block and to the predictor
  task automatic send_event(op_e op, logic [103:0] d);
    while (!no_idle && $urandom_range(99) < 9) @(posedge clk_i);
    s_axis_tvalid <= 1; s_axis_tuser <= op; s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_event(op, d);
    s_axis_tvalid <= 0;
    n_sent++;
    @(posedge clk_i);
  endtask

  task automatic start_move(bit dir, logic [17:0] req, logic [30:0] steps, bit cont);
    send_event(OP_START, {5'b0, 48'b0, cont, steps, req, dir});
  endtask

  // fire the alarm the block asked for, or a random time if none pending
  task automatic fire_alarm();
    logic [47:0] t;
    t = (sb.pending_q.size() != 0 && sb.pending_q[$][102]) ? sb.pending_q[$][101:54]
        : {$urandom, $urandom};
    send_event(OP_ALARM, {5'b0, t, 51'b0});
  endtask

  task automatic drain(int extra);
    int guard;
    guard = 0;
    while (sb.pending_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i); guard++;
    end
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic random_regs(bit extreme);
    apb_write(REG_MAX_SPEED, extreme ? 18'h3ffff : $urandom_range(262143, 1));
    apb_write(REG_START_SPEED, extreme ? 1 : $urandom_range(3000, 1));
    apb_write(REG_ACCEL, extreme ? 24'hffffff : $urandom_range(200000, 1));
    apb_write(REG_TIMER_RATE, extreme ? 100000000 : $urandom_range(100000000, 1));
    apb_write(REG_PERIOD_MIN, extreme ? 1 : $urandom_range(50, 1));
    apb_write(REG_PERIOD_MAX, extreme ? 24'hffffff : $urandom_range(16777215, 1000));
  endtask

  // a well-formed move with random content, sometimes interrupted
  task automatic run_move();
    int len;
    start_move($urandom_range(1), $urandom_range(262143) >> $urandom_range(17),
               $urandom_range(30), $urandom_range(9) == 0);
    len = $urandom_range(70, 5);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(39))
        0: send_event(OP_STOP, {$urandom, $urandom, $urandom, $urandom});
        1: send_event(OP_ZERO, {$urandom, $urandom, $urandom, $urandom});
        2: send_event(OP_START, {$urandom, $urandom, $urandom, $urandom});
        default: fire_alarm();
      endcase
      if (sb.mode == MODE_IDLE && $urandom_range(3) != 0) break;
    end
  endtask

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_state();
    n_sent = 0;
    no_idle = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: idle events, extremes, stop, zero, long and wrapping moves
    fire_alarm();
    send_event(OP_STOP, '0);
    send_event(OP_ZERO, '1);
    start_move(1, 18'h3ffff, 31'h7fffffff, 0);
    repeat (4) fire_alarm();
    send_event(OP_STOP, '0);
    fire_alarm();
    start_move(0, 0, 0, 0);
    repeat (3) fire_alarm();
    start_move(1, 1200, 6, 0);
    repeat (8) fire_alarm();
    start_move(0, 700, 2, 1);
    send_event(OP_ALARM, {5'b0, 48'hffffffffffff, 51'b0});
    repeat (3) fire_alarm();
    send_event(OP_ZERO, '0);
    drain(150);

    random_regs(1);
    start_move(1, 18'h3ffff, 40, 0);
    repeat (12) fire_alarm();
    drain(150);
    apb_write(REG_ACCEL, 0);
    apb_write(REG_START_SPEED, 0);
    start_move(0, 5000, 4, 0);
    repeat (10) fire_alarm();
    drain(150);

    // random phases; some load fresh settings, others keep the last ones
    for (int ph = 0; n_sent < 1050; ph++) begin
      no_idle = (ph == 3);
      if (ph == 0) random_regs(0);
      else if (ph % 4 == 1) begin
        random_regs(0);
        apb_write(REG_START_SPEED, 500);
        apb_write(REG_PERIOD_MAX, 100000);
      end else if (ph % 4 == 2) random_regs(0);
      for (int m = 0; m < 12 && n_sent < 1050; m++) run_move();
      drain(150);
    end

    no_idle = 0;
    drain(150);
    if (sb.pending_q.size() == 0 && sb.fails == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> files.f
rtl/strg_pkg.sv
rtl/strg_div.sv
rtl/stepper_trapezoid_ramp_generator.sv
tb/sv/tb_top.sv
